>>> hw/rtl/cartridge_real_time_clock_macros.svh
// Assertion helpers shared by the clock RTL.
// Every check samples on clk and is disabled while rst_n is low.
`ifndef CARTRIDGE_REAL_TIME_CLOCK_MACROS_SVH
`define CARTRIDGE_REAL_TIME_CLOCK_MACROS_SVH

// Same-cycle implication.
`define CRTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clock check failed");

// Next-cycle implication.
`define CRTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clock check failed");

`endif

>>> hw/rtl/crtc_pkg.sv
`timescale 1ns / 1ps

package crtc_pkg;

  localparam int TPS_W     = 24;
  localparam int SEC_W     = 6;
  localparam int MIN_W     = 6;
  localparam int HOUR_W    = 5;
  localparam int DAY_W     = 9;
  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 8;

  localparam logic [TPS_W-1:0] TPS_RESET = 24'd32768;

  localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;

  // Bit positions in the day high / flags byte
  localparam int DAY8_BIT  = 0;
  localparam int HALT_BIT  = 6;
  localparam int CARRY_BIT = 7;

  // Transaction functions
  localparam logic [FUNC_W-1:0] FN_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LATCH = 2'd2;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SEC    = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_HOUR   = 3'd2;
  localparam logic [IDX_W-1:0] REG_DAY_LO = 3'd3;
  localparam logic [IDX_W-1:0] REG_DAY_HI = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] wdata;
  } item_t;

endpackage

>>> hw/rtl/cartridge_real_time_clock.sv
`timescale 1ns / 1ps
`include "cartridge_real_time_clock_macros.svh"

// Cartridge real-time clock: prescaler, seconds, minutes, hours and a 9-bit
// day counter with sticky carry and halt. Takes one transaction per cycle
// while in_stall is low; each transaction gives exactly one result, held
// first in the input register and then in the result register. The
// counters update as a transaction moves from the input register to the
// result register, so a full result register held by out_stall backs up
// into in_stall only once the input register is also full. The prescaler
// divisor comes from cfg_wdata and resets to 32768; write it only while idle.
module cartridge_real_time_clock (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [crtc_pkg::TPS_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [crtc_pkg::FUNC_W-1:0] in_func,
  input  logic [crtc_pkg::IDX_W-1:0]  in_reg_index,
  input  logic [crtc_pkg::DATA_W-1:0] in_wdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [crtc_pkg::DATA_W-1:0] out_rdata
);

  logic                        in_full_r, in_full_nxt;
  crtc_pkg::item_t             item_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [crtc_pkg::DATA_W-1:0] out_rdata_r;
  logic [crtc_pkg::DATA_W-1:0] core_rdata;
  logic                        accept;
  logic                        move;

  assign move     = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_full_nxt = in_full_r;
    if (accept) begin
      in_full_nxt = 1'b1;
    end else if (move) begin
      in_full_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold item until it moves, hold result while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{func: in_func, reg_index: in_reg_index, wdata: in_wdata};
    end
    if (move) begin
      out_rdata_r <= core_rdata;
    end
  end

  crtc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_wdata (cfg_wdata),
    .fire      (move),
    .item      (item_r),
    .rdata     (core_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_rdata = out_rdata_r;

  `CRTC_ASSERT_NOW(a_stall_only_when_full, in_stall, in_full_r && out_valid_r)
  `CRTC_ASSERT_NEXT(a_move_makes_result, move, out_valid_r)

endmodule

>>> hw/rtl/crtc_core.sv
`timescale 1ns / 1ps
`include "cartridge_real_time_clock_macros.svh"

module crtc_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [crtc_pkg::TPS_W-1:0] cfg_wdata,
  input  logic                       fire,
  input  crtc_pkg::item_t            item,
  output logic [crtc_pkg::DATA_W-1:0] rdata
);

  logic [crtc_pkg::TPS_W-1:0]  tps_r;
  logic [crtc_pkg::TPS_W-1:0]  pre_r, pre_nxt;
  logic [crtc_pkg::SEC_W-1:0]  sec_r, sec_nxt;
  logic [crtc_pkg::MIN_W-1:0]  min_r, min_nxt;
  logic [crtc_pkg::HOUR_W-1:0] hour_r, hour_nxt;
  logic [crtc_pkg::DAY_W-1:0]  day_r, day_nxt;
  logic                        halt_r, halt_nxt;
  logic                        carry_r, carry_nxt;

  logic [crtc_pkg::SEC_W-1:0]  lat_sec_r, lat_sec_nxt;
  logic [crtc_pkg::MIN_W-1:0]  lat_min_r, lat_min_nxt;
  logic [crtc_pkg::HOUR_W-1:0] lat_hour_r, lat_hour_nxt;
  logic [crtc_pkg::DAY_W-1:0]  lat_day_r, lat_day_nxt;
  logic                        lat_halt_r, lat_halt_nxt;
  logic                        lat_carry_r, lat_carry_nxt;

  logic [crtc_pkg::TPS_W:0]    pre_inc, pre_wrap;
  logic                        sec_roll;
  logic                        sec_c, min_c, hour_c;
  logic [crtc_pkg::SEC_W-1:0]  sec_adv;
  logic [crtc_pkg::MIN_W-1:0]  min_adv;
  logic [crtc_pkg::HOUR_W-1:0] hour_adv;

  // Prescaler: one divisor subtracted at most per tick
  assign pre_inc  = {1'b0, pre_r} + (crtc_pkg::TPS_W+1)'(1);
  assign sec_roll = pre_inc >= {1'b0, tps_r};
  assign pre_wrap = sec_roll ? pre_inc - {1'b0, tps_r} : pre_inc;

  // Out-of-range values run up to the field max and wrap with no carry
  assign sec_c    = sec_r == crtc_pkg::SEC_LAST;
  assign min_c    = min_r == crtc_pkg::MIN_LAST;
  assign hour_c   = hour_r == crtc_pkg::HOUR_LAST;
  assign sec_adv  = sec_c  ? '0 : sec_r  + crtc_pkg::SEC_W'(1);
  assign min_adv  = min_c  ? '0 : min_r  + crtc_pkg::MIN_W'(1);
  assign hour_adv = hour_c ? '0 : hour_r + crtc_pkg::HOUR_W'(1);

  always_comb begin
    pre_nxt       = pre_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    day_nxt       = day_r;
    halt_nxt      = halt_r;
    carry_nxt     = carry_r;
    lat_sec_nxt   = lat_sec_r;
    lat_min_nxt   = lat_min_r;
    lat_hour_nxt  = lat_hour_r;
    lat_day_nxt   = lat_day_r;
    lat_halt_nxt  = lat_halt_r;
    lat_carry_nxt = lat_carry_r;
    if (fire) begin
      case (item.func)
        crtc_pkg::FN_TICK: begin
          if (!halt_r) begin
            pre_nxt = pre_wrap[crtc_pkg::TPS_W-1:0];
            if (sec_roll) begin
              sec_nxt = sec_adv;
              if (sec_c) begin
                min_nxt = min_adv;
                if (min_c) begin
                  hour_nxt = hour_adv;
                  if (hour_c) begin
                    day_nxt = day_r + crtc_pkg::DAY_W'(1);
                    if (&day_r) begin
                      carry_nxt = 1'b1;
                    end
                  end
                end
              end
            end
          end
        end
        crtc_pkg::FN_WRITE: begin
          case (item.reg_index)
            crtc_pkg::REG_SEC: begin
              sec_nxt = item.wdata[crtc_pkg::SEC_W-1:0];
              pre_nxt = '0;
            end
            crtc_pkg::REG_MIN: begin
              min_nxt = item.wdata[crtc_pkg::MIN_W-1:0];
            end
            crtc_pkg::REG_HOUR: begin
              hour_nxt = item.wdata[crtc_pkg::HOUR_W-1:0];
            end
            crtc_pkg::REG_DAY_LO: begin
              day_nxt = {day_r[crtc_pkg::DAY_W-1], item.wdata};
            end
            crtc_pkg::REG_DAY_HI: begin
              day_nxt   = {item.wdata[crtc_pkg::DAY8_BIT], day_r[crtc_pkg::DAY_W-2:0]};
              halt_nxt  = item.wdata[crtc_pkg::HALT_BIT];
              carry_nxt = item.wdata[crtc_pkg::CARRY_BIT];
            end
            default: begin
              // drop writes to unknown registers
            end
          endcase
        end
        crtc_pkg::FN_LATCH: begin
          lat_sec_nxt   = sec_r;
          lat_min_nxt   = min_r;
          lat_hour_nxt  = hour_r;
          lat_day_nxt   = day_r;
          lat_halt_nxt  = halt_r;
          lat_carry_nxt = carry_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rdata = '0;
    if (item.func == crtc_pkg::FN_READ) begin
      case (item.reg_index)
        crtc_pkg::REG_SEC:    rdata = crtc_pkg::DATA_W'(lat_sec_r);
        crtc_pkg::REG_MIN:    rdata = crtc_pkg::DATA_W'(lat_min_r);
        crtc_pkg::REG_HOUR:   rdata = crtc_pkg::DATA_W'(lat_hour_r);
        crtc_pkg::REG_DAY_LO: rdata = lat_day_r[crtc_pkg::DATA_W-1:0];
        crtc_pkg::REG_DAY_HI: rdata = {lat_carry_r, lat_halt_r, 5'b0,
                                       lat_day_r[crtc_pkg::DAY_W-1]};
        default:              rdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= crtc_pkg::TPS_RESET;
      pre_r       <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= '0;
      day_r       <= '0;
      halt_r      <= 1'b0;
      carry_r     <= 1'b0;
      lat_sec_r   <= '0;
      lat_min_r   <= '0;
      lat_hour_r  <= '0;
      lat_day_r   <= '0;
      lat_halt_r  <= 1'b0;
      lat_carry_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tps_r <= cfg_wdata;
      end
      pre_r       <= pre_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      day_r       <= day_nxt;
      halt_r      <= halt_nxt;
      carry_r     <= carry_nxt;
      lat_sec_r   <= lat_sec_nxt;
      lat_min_r   <= lat_min_nxt;
      lat_hour_r  <= lat_hour_nxt;
      lat_day_r   <= lat_day_nxt;
      lat_halt_r  <= lat_halt_nxt;
      lat_carry_r <= lat_carry_nxt;
    end
  end

  `CRTC_ASSERT_NEXT(a_halt_freezes, fire && item.func == crtc_pkg::FN_TICK && halt_r, $stable(pre_r) && $stable(sec_r) && $stable(day_r))
  `CRTC_ASSERT_NEXT(a_sec_write_clears_pre, fire && item.func == crtc_pkg::FN_WRITE && item.reg_index == crtc_pkg::REG_SEC, pre_r == '0)
  `CRTC_ASSERT_NEXT(a_carry_sticky, carry_r && !(fire && item.func == crtc_pkg::FN_WRITE && item.reg_index == crtc_pkg::REG_DAY_HI), carry_r)

endmodule
